### rtl/jbvm_pkg.sv
// ----------------------------------------------------------------------------
// jbvm_pkg: shared constants and helpers of the voice mixer
// Sizes of the speaker queues, store addressing and 16-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package jbvm_pkg;

  localparam int SPEAKERS      = 8;
  localparam int FRAME_SAMPLES = 256;
  localparam int QUEUE_FRAMES  = 8;

  localparam int SPK_W   = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
  localparam int SLOT_W  = (QUEUE_FRAMES > 1) ? $clog2(QUEUE_FRAMES) : 1;
  localparam int POS_W   = $clog2(FRAME_SAMPLES);
  localparam int FILL_W  = $clog2(FRAME_SAMPLES + 1);
  localparam int QCNT_W  = $clog2(QUEUE_FRAMES + 1);

  localparam int STORE_DEPTH = SPEAKERS * QUEUE_FRAMES * FRAME_SAMPLES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int PRIME_W    = 4;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 2;
  localparam int GAIN_SHIFT = 12;

  localparam logic [PRIME_W-1:0] PRIME_RESET = 4'd3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_MIX  = 1'b1;

  // Saturate a wide signed value to the 16-bit sample range
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > PROD_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -PROD_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  // Flat frame store address of one sample of one queued frame
  function automatic logic [ADDR_W-1:0] store_addr(input logic [SPK_W-1:0]  spk,
                                                   input logic [SLOT_W-1:0] slot,
                                                   input logic [POS_W-1:0]  pos);
    return ADDR_W'((int'(spk) * QUEUE_FRAMES + int'(slot)) * FRAME_SAMPLES + int'(pos));
  endfunction

endpackage

`default_nettype wire

### rtl/jbvm_in_if.sv
// ----------------------------------------------------------------------------
// jbvm_in_if: input item channel
// Push and mix commands with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbvm_in_if import jbvm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [2:0]                 speaker;
  logic signed [SAMPLE_W-1:0] sample;
  logic [GAIN_W-1:0]          gain;
  logic                       frame_end;

  modport source (output valid, operation, speaker, sample, gain, frame_end, input ready);
  modport sink   (input valid, operation, speaker, sample, gain, frame_end, output ready);
endinterface

`default_nettype wire

### rtl/jbvm_out_if.sv
// ----------------------------------------------------------------------------
// jbvm_out_if: mixed sample channel
// One mixed sample per beat with frame and overflow markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbvm_out_if import jbvm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic                       frame_last;
  logic                       overflow_seen;

  modport source (output valid, mixed_sample, frame_last, overflow_seen, input ready);
  modport sink   (input valid, mixed_sample, frame_last, overflow_seen, output ready);
endinterface

`default_nettype wire

### rtl/jbvm_cfg_if.sv
// ----------------------------------------------------------------------------
// jbvm_cfg_if: configuration write channel
// Carries the prime depth register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbvm_cfg_if import jbvm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRIME_W-1:0] prime_depth;

  modport source (output valid, prime_depth, input ready);
  modport sink   (input valid, prime_depth, output ready);
endinterface

`default_nettype wire

### rtl/jitter_buffered_voice_mixer.sv
// ----------------------------------------------------------------------------
// jitter_buffered_voice_mixer: per-speaker jitter buffered voice mixer
// Gathers scaled speaker samples into frame queues and mixes active queues.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Payload
//  in_ch    in   valid/ready    operation, speaker, sample, gain, frame_end
//  out_ch   out  valid/ready    mixed_sample, frame_last, overflow_seen
//  cfg_ch   in   valid/ready    prime_depth (always ready)
//
//  A push beat is accepted, then multiplied, then written to the store.
//  A mix beat selects the active set, reads the frame store once per speaker
//  slot through its single read port, accumulates, then hands on its result.
//  A mix result waits in the output register; the next beat is taken meanwhile,
//  but a later mix result holds until that register is free.
//  Reset (synchronous, rst_n low) clears all queue state; the frame store
//  itself is not cleared, committed frames are always fully written.
// ----------------------------------------------------------------------------
`default_nettype none

module jitter_buffered_voice_mixer import jbvm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  jbvm_in_if.sink   in_ch,
  jbvm_out_if.source out_ch,
  jbvm_cfg_if.sink  cfg_ch
);

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_PUSH_MUL = 7'b0000010,
    ST_PUSH_WR  = 7'b0000100,
    ST_MIX_SEL  = 7'b0001000,
    ST_MIX_RD   = 7'b0010000,
    ST_MIX_ACC  = 7'b0100000,
    ST_MIX_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Captured input beat
  logic [SPK_W-1:0]           spk_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [GAIN_W-1:0]          gain_r;
  logic                       frame_end_r;

  // Configuration
  logic [PRIME_W-1:0] prime_r;

  // Per-speaker queue state
  logic [SLOT_W-1:0] wslot_r   [SPEAKERS];
  logic [SLOT_W-1:0] rslot_r   [SPEAKERS];
  logic [QCNT_W-1:0] queued_r  [SPEAKERS];
  logic [FILL_W-1:0] fill_r    [SPEAKERS];
  logic [SPEAKERS-1:0] blocked_r;
  logic [SPEAKERS-1:0] started_r;
  logic [SPEAKERS-1:0] active_r;
  logic [POS_W-1:0]    opos_r;
  logic                overflow_r;

  // Shared arithmetic: product register and mix accumulator
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] acc_r;
  logic                       acc_en_r;
  logic [SPK_W-1:0]           cnt_r;

  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;
  logic                       out_ovf_r;

  // Frame store ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic in_fire;
  logic out_free;
  logic spk_in_range;
  logic last_pos;

  // Push decode
  logic [FILL_W-1:0]          push_pos;
  logic                       push_room;
  logic                       push_blk;
  logic signed [PROD_W-1:0]   quot;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SAMPLE_W-1:0] acc_sum;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign spk_in_range = (32'(in_ch.speaker) < SPEAKERS);
  assign last_pos     = (opos_r == POS_W'(FRAME_SAMPLES - 1));

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mixed_sample  = out_sample_r;
  assign out_ch.frame_last    = out_last_r;
  assign out_ch.overflow_seen = out_ovf_r;

  // Truncate toward zero: bias negative products before the arithmetic shift
  always_comb begin
    push_pos  = fill_r[spk_r];
    push_room = (push_pos < FILL_W'(FRAME_SAMPLES));
    push_blk  = blocked_r[spk_r] ||
                (push_room && (queued_r[spk_r] >= QCNT_W'(QUEUE_FRAMES)));
    quot      = (prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << GAIN_SHIFT) - 1) : PROD_W'(0)))
                >>> GAIN_SHIFT;
    scaled    = sat16(quot);
    acc_sum   = sat16(PROD_W'(acc_r) + PROD_W'($signed(ram_rdata)));
  end

  assign ram_we    = (state_r == ST_PUSH_WR) && push_room && !push_blk;
  assign ram_waddr = store_addr(spk_r, wslot_r[spk_r], push_pos[POS_W-1:0]);
  assign ram_wdata = scaled;
  assign ram_raddr = store_addr(cnt_r, rslot_r[cnt_r], opos_r);

  jbvm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == OP_MIX) begin
            state_nxt = ST_MIX_SEL;
          end else if (spk_in_range) begin
            state_nxt = ST_PUSH_MUL;
          end
        end
      end
      ST_PUSH_MUL: state_nxt = ST_PUSH_WR;
      ST_PUSH_WR:  state_nxt = ST_IDLE;
      ST_MIX_SEL:  state_nxt = ST_MIX_RD;
      ST_MIX_RD: begin
        if (cnt_r == SPK_W'(SPEAKERS - 1)) begin
          state_nxt = ST_MIX_ACC;
        end
      end
      ST_MIX_ACC:  state_nxt = ST_MIX_OUT;
      ST_MIX_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the beat and run the shared multiplier
  always_ff @(posedge clk) begin
    if (in_fire) begin
      spk_r       <= SPK_W'(in_ch.speaker);
      sample_r    <= in_ch.sample;
      gain_r      <= in_ch.gain;
      frame_end_r <= in_ch.frame_end;
    end
    if (state_r == ST_PUSH_MUL) begin
      prod_r <= PROD_W'(sample_r) * $signed({2'b00, gain_r});
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= PRIME_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      prime_r <= cfg_ch.prime_depth;
    end
  end

  // Mix read walk: one slot per cycle, accumulate the read data in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      acc_en_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      acc_en_r <= (state_r == ST_MIX_RD) && active_r[cnt_r];
      if (state_r == ST_MIX_SEL) begin
        cnt_r <= '0;
        acc_r <= '0;
      end else begin
        if (state_r == ST_MIX_RD) begin
          cnt_r <= cnt_r + SPK_W'(1);
        end
        if (acc_en_r) begin
          acc_r <= acc_sum;
        end
      end
    end
  end

  // Queue bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SPEAKERS; s++) begin
        wslot_r[s]  <= '0;
        rslot_r[s]  <= '0;
        queued_r[s] <= '0;
        fill_r[s]   <= '0;
      end
      blocked_r  <= '0;
      started_r  <= '0;
      active_r   <= '0;
      opos_r     <= '0;
      overflow_r <= 1'b0;
    end else begin
      // Push: store the scaled sample, commit only a complete unblocked frame
      if (state_r == ST_PUSH_WR) begin
        if (frame_end_r) begin
          if (push_pos == FILL_W'(FRAME_SAMPLES - 1)) begin
            if (push_blk) begin
              overflow_r <= 1'b1;
            end else begin
              wslot_r[spk_r]  <= (wslot_r[spk_r] == SLOT_W'(QUEUE_FRAMES - 1)) ?
                                 '0 : wslot_r[spk_r] + SLOT_W'(1);
              queued_r[spk_r] <= queued_r[spk_r] + QCNT_W'(1);
            end
          end
          fill_r[spk_r]    <= '0;
          blocked_r[spk_r] <= 1'b0;
        end else if (push_room) begin
          fill_r[spk_r]    <= push_pos + FILL_W'(1);
          blocked_r[spk_r] <= push_blk;
        end
      end
      // Frame start: choose the active set, latch the started flags
      if ((state_r == ST_MIX_SEL) && (opos_r == '0)) begin
        for (int s = 0; s < SPEAKERS; s++) begin
          if (queued_r[s] == '0) begin
            active_r[s] <= 1'b0;
          end else begin
            started_r[s] <= started_r[s] || (32'(queued_r[s]) >= 32'(prime_r));
            active_r[s]  <= started_r[s] || (32'(queued_r[s]) >= 32'(prime_r));
          end
        end
      end
      // Result handed over: advance position, pop active queues at frame end
      if ((state_r == ST_MIX_OUT) && out_free) begin
        if (last_pos) begin
          for (int s = 0; s < SPEAKERS; s++) begin
            if (active_r[s]) begin
              rslot_r[s]  <= (rslot_r[s] == SLOT_W'(QUEUE_FRAMES - 1)) ?
                             '0 : rslot_r[s] + SLOT_W'(1);
              queued_r[s] <= queued_r[s] - QCNT_W'(1);
            end
          end
          opos_r <= '0;
        end else begin
          opos_r <= opos_r + POS_W'(1);
        end
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_MIX_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_MIX_OUT) && out_free) begin
      out_sample_r <= acc_r;
      out_last_r   <= last_pos;
      out_ovf_r    <= overflow_r;
    end
  end

endmodule

`default_nettype wire

### rtl/jbvm_ram.sv
// ----------------------------------------------------------------------------
// jbvm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jbvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/jbvm_checker.sv
// ----------------------------------------------------------------------------
// jbvm_checker: port-level checks of the voice mixer
// Watches the channel ports only; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jbvm_checker import jbvm_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_operation,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SAMPLE_W-1:0] out_mixed_sample,
  input wire logic                out_frame_last,
  input wire logic                out_overflow_seen
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // A mix beat occupies the sequencer and holds off further input
  a_mix_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_operation == OP_MIX)) |=> !in_ready)
    else $error("input taken right after a mix beat");

  // A push beat never produces a result
  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_operation == OP_PUSH) && !out_valid) |=> !out_valid)
    else $error("result appeared after a push beat");

  // A result is only loaded while the input side is busy
  a_result_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a mix in progress");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_mixed_sample) && $stable(out_frame_last) &&
       $stable(out_overflow_seen)))
    else $error("stalled result changed");

endmodule

bind jitter_buffered_voice_mixer jbvm_checker u_jbvm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_operation      (in_ch.operation),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_mixed_sample  (out_ch.mixed_sample),
  .out_frame_last    (out_ch.frame_last),
  .out_overflow_seen (out_ch.overflow_seen)
);

`default_nettype wire
